// File: rtl/cis_pkg.sv
package cis_pkg;

   localparam int MaxPattern = 16;
   localparam int TextMax    = 65536;
   localparam int ByteW      = 8;
   localparam int LenW       = $clog2(MaxPattern + 1);
   localparam int IdxW       = $clog2(MaxPattern);
   localparam int SeenW      = $clog2(TextMax + 1);
   localparam int StartW     = 16;
   localparam int CsrAddrW   = 2;
   localparam int CsrDataW   = 64;
   localparam int HalfBytes  = CsrDataW / ByteW;

   localparam logic [CsrAddrW-1:0] RegPatLow  = CsrAddrW'(0);
   localparam logic [CsrAddrW-1:0] RegPatHigh = CsrAddrW'(1);
   localparam logic [CsrAddrW-1:0] RegPatLen  = CsrAddrW'(2);

   localparam logic [LenW-1:0]   LenMax   = LenW'(MaxPattern);
   localparam logic [SeenW-1:0]  SeenMax  = SeenW'(TextMax);
   localparam logic [StartW-1:0] StartMax = {StartW{1'b1}};

   typedef logic [ByteW-1:0] char_type;

   typedef struct packed {
      char_type [MaxPattern-1:0] chars;
      logic [LenW-1:0]           len;
   } pattern_type;

   function automatic char_type fold_case(input char_type c);
      char_type r;
      r = c;
      if (c >= char_type'("A") && c <= char_type'("Z")) begin
         r = c + char_type'(32);
      end
      return r;
   endfunction

endpackage

// File: rtl/cis_cfg_regs.sv
module cis_cfg_regs
   import cis_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata,
   output pattern_type         pattern
);

   char_type [MaxPattern-1:0] chars_ff;
   char_type [MaxPattern-1:0] chars_in;
   logic [LenW-1:0]           len_ff;
   logic [LenW-1:0]           len_in;
   logic [LenW-1:0]           wlen;

   always_comb begin
      chars_in = chars_ff;
      len_in   = len_ff;
      wlen     = csr_wdata[LenW-1:0];
      if (csr_we) begin
         case (csr_addr)
            RegPatLow: begin
               for (int k = 0; k < HalfBytes; k++) begin
                  chars_in[k] = fold_case(csr_wdata[k*ByteW +: ByteW]);
               end
            end
            RegPatHigh: begin
               for (int k = 0; k < HalfBytes; k++) begin
                  chars_in[k+HalfBytes] = fold_case(csr_wdata[k*ByteW +: ByteW]);
               end
            end
            RegPatLen: begin
               len_in = (wlen > LenMax) ? LenMax : wlen;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= '0;
         len_ff   <= '0;
      end else begin
         chars_ff <= chars_in;
         len_ff   <= len_in;
      end
   end

   assign pattern.chars = chars_ff;
   assign pattern.len   = len_ff;

endmodule

// File: rtl/cis_matcher.sv
module cis_matcher
   import cis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  char_type          text_byte,
   input  logic              end_of_text,
   input  pattern_type       pattern,
   output logic              hit,
   output logic              found,
   output logic [StartW-1:0] start
);

   char_type [MaxPattern-1:0] win_ff;
   char_type [MaxPattern-1:0] win_in;
   logic [SeenW-1:0]          seen_ff;
   logic [SeenW-1:0]          seen_in;
   logic                      reported_ff;
   logic                      reported_in;

   char_type [MaxPattern-1:0] new_win;
   char_type [MaxPattern-1:0] aligned;
   logic [MaxPattern-1:0]     cmp_ok;
   logic [SeenW-1:0]          seen_inc;
   logic [SeenW-1:0]          start_full;
   logic [IdxW-1:0]           idx;
   logic                      win_match;
   logic                      long_enough;

   // shifted window and pattern right-aligned to the newest byte
   always_comb begin
      new_win[0] = fold_case(text_byte);
      for (int j = 1; j < MaxPattern; j++) begin
         new_win[j] = win_ff[j-1];
      end
      for (int j = 0; j < MaxPattern; j++) begin
         idx        = IdxW'(pattern.len - LenW'(1) - LenW'(j));
         aligned[j] = pattern.chars[idx];
         cmp_ok[j]  = (LenW'(j) >= pattern.len) || (new_win[j] == aligned[j]);
      end
   end

   assign win_match   = &cmp_ok;
   assign seen_inc    = (seen_ff == SeenMax) ? seen_ff : seen_ff + SeenW'(1);
   assign long_enough = seen_inc >= SeenW'(pattern.len);
   assign start_full  = seen_inc - SeenW'(pattern.len);

   always_comb begin
      win_in      = win_ff;
      seen_in     = seen_ff;
      reported_in = reported_ff;
      hit         = 1'b0;
      found       = 1'b0;
      start       = '0;
      if (step) begin
         if (end_of_text) begin
            hit         = !reported_ff;
            found       = (pattern.len == '0);
            win_in      = '0;
            seen_in     = '0;
            reported_in = 1'b0;
         end else if (!reported_ff) begin
            if (pattern.len == '0) begin
               hit         = 1'b1;
               found       = 1'b1;
               reported_in = 1'b1;
            end else begin
               win_in  = new_win;
               seen_in = seen_inc;
               if (long_enough && win_match) begin
                  hit         = 1'b1;
                  found       = 1'b1;
                  reported_in = 1'b1;
                  start       = (start_full > SeenW'(StartMax)) ? StartMax
                                                               : start_full[StartW-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else begin
         win_ff      <= win_in;
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

endmodule

// File: rtl/caseless_substring_search.sv
// Case-insensitive substring search over a byte stream. Load the pattern (up to 16 bytes,
// byte 0 first) into registers 0 and 1 and its length into register 2 while the block is
// idle; only the low five bits of the length count, values above 16 act as 16, and zero is
// an empty pattern that matches at offset 0 on the first word of a text. Each req word
// carries one text byte, and a word with tlast set ends the text (its byte is ignored) and
// starts a new one. ASCII letters compare without regard to case. One rsp word comes per
// text: at the byte that completes the first match (found set, start offset), or at the
// end-of-text word when nothing matched. Offsets saturate at 65535. The block takes one
// word per clock unless a stalled rsp side holds it: a word is registered on entry, the
// 16-byte window compare runs on the registered word, and the result sits in an output
// register; a stalled rsp side holds the input side only once both registers are full.
module caseless_substring_search
   import cis_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // text_byte
   input  logic                req_tlast,   // end_of_text
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // match_start
   output logic                rsp_tuser,   // match_found
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata
);

   pattern_type       pattern;
   logic              step;
   logic              hit;
   logic              found;
   logic [StartW-1:0] start;

   logic              in_valid_ff;
   logic              in_valid_in;
   char_type          in_byte_ff;
   logic              in_last_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_found_ff;
   logic [StartW-1:0] out_start_ff;

   cis_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .pattern   (pattern)
   );

   cis_matcher u_match (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .pattern     (pattern),
      .hit         (hit),
      .found       (found),
      .start       (start)
   );

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (hit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (hit) begin
         out_found_ff <= found;
         out_start_ff <= start;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_start_ff;
   assign rsp_tuser  = out_found_ff;

endmodule

// File: dv/caseless_substring_search_test.sv
`timescale 1ns / 1ps

module caseless_substring_search_test;
   import cis_pkg::*;

   typedef struct packed {
      logic              found;
      logic [StartW-1:0] start;
   } match_type;

   typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [CsrAddrW-1:0] addr;
      logic [CsrDataW-1:0] wdata;
      char_type            text;
      logic                eot;
      logic                typed;
      logic                produced;
      match_type           want;
   } row_type;

   localparam match_type FoundAtZero = '{found: 1'b1, start: '0};
   localparam match_type NotFound    = '{found: 1'b0, start: '0};
   localparam int CycleLimit      = 800000;
   localparam int HoldOffCycles   = 300;
   localparam int SettleCycles    = 8;
   localparam int WordsPerSetting = 64;

   localparam logic [LenW-1:0] SettingLens [9] =
      '{5'd2, 5'd0, 5'd16, 5'd4, 5'd31, 5'd1, 5'd7, 5'd17, 5'd3};
   localparam char_type EdgeBytes [6] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF};

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;   // text_byte
   logic                req_tlast  = 1'b0; // end_of_text
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;         // match_start
   logic                rsp_tuser;         // match_found
   logic                csr_we     = 1'b0;
   logic [CsrAddrW-1:0] csr_addr   = '0;
   logic [CsrDataW-1:0] csr_wdata  = '0;

   caseless_substring_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // pattern mirrored from the register writes, search state from the words accepted so far
   logic [CsrDataW-1:0] pat_lo  = '0;
   logic [CsrDataW-1:0] pat_hi  = '0;
   logic [LenW-1:0]     pat_len = '0;
   char_type            window_q [MaxPattern];
   logic [SeenW-1:0]    seen_q;
   logic                reported_q;

   match_type expected_matches [$];

   int send_idle_pct = 29;
   int recv_idle_pct = 84;
   int words_sent, texts_sent, results_checked, errors, settings_used;
   int cycles = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;

   row_type plan [30] = '{
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h78, 1'b0, 1'b1, 1'b1, FoundAtZero},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h79, 1'b0, 1'b1, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b1, 1'b1, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b1, 1'b1, 1'b1, FoundAtZero},
      '{ROW_WRITE, RegPatLow,  64'hDEAD_BEEF_C000_7A41, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WRITE, RegPatLen,  64'd3, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h61, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h5A, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b1, 1'b1, FoundAtZero},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h42, 1'b1, 1'b1, 1'b0, NotFound},
      '{ROW_WRITE, RegPatLow,  '1,    8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WRITE, RegPatHigh, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WRITE, RegPatLen,  64'd31, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, NotFound},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h00, 1'b0, 1'b1, 1'b1, FoundAtZero},
      '{ROW_WORD,  RegPatLow,  64'h0, 8'h55, 1'b1, 1'b1, 1'b0, NotFound}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic char_type lower_letter(input char_type b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

   function automatic char_type flip_case(input char_type b);
      char_type low;
      low = b | 8'h20;
      if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1) == 1) begin
         return b ^ 8'h20;
      end
      return b;
   endfunction

   function automatic logic [LenW-1:0] used_len();
      return (pat_len > LenMax) ? LenMax : pat_len;
   endfunction

   function automatic char_type raw_pattern_byte(input int k);
      logic [CsrDataW-1:0] half;
      half = (k < HalfBytes) ? pat_lo : pat_hi;
      return half[(k % HalfBytes) * ByteW +: ByteW];
   endfunction

   function automatic char_type noise_byte();
      logic [LenW-1:0] eff;
      eff = used_len();
      case ($urandom_range(3))
         0: begin
            return char_type'($urandom);
         end
         1: begin
            return flip_case(char_type'($urandom_range(8'h7A, 8'h61)));
         end
         default: begin
            if (eff == 0) begin
               return char_type'($urandom);
            end
            return flip_case(raw_pattern_byte($urandom_range(eff - 1)));
         end
      endcase
   endfunction

   function automatic logic [CsrDataW-1:0] random_pattern_word();
      logic [CsrDataW-1:0] w;
      int k;
      for (k = 0; k < HalfBytes; k++) begin
         case ($urandom_range(4))
            0, 1, 2: w[k*ByteW +: ByteW] = flip_case(char_type'($urandom_range(8'h7A, 8'h61)));
            3:       w[k*ByteW +: ByteW] = EdgeBytes[$urandom_range(5)];
            default: w[k*ByteW +: ByteW] = char_type'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic search_step(input char_type b, input logic eot,
                              output bit got, output match_type r);
      logic [LenW-1:0]  eff;
      logic [SeenW-1:0] offset;
      bit               hit;
      int               k;
      eff = used_len();
      got = 1'b0;
      r   = NotFound;
      if (eot) begin
         if (!reported_q) begin
            got     = 1'b1;
            r.found = (eff == 0);
         end
         foreach (window_q[k]) window_q[k] = '0;
         seen_q     = '0;
         reported_q = 1'b0;
      end else if (!reported_q) begin
         if (eff == 0) begin
            reported_q = 1'b1;
            got        = 1'b1;
            r          = FoundAtZero;
         end else begin
            for (k = MaxPattern - 1; k > 0; k--) window_q[k] = window_q[k-1];
            window_q[0] = lower_letter(b);
            if (seen_q < SeenMax) seen_q = seen_q + 1'b1;
            if (seen_q >= eff) begin
               hit = 1'b1;
               for (k = 0; k < eff; k++) begin
                  if (window_q[eff - 1 - k] != lower_letter(raw_pattern_byte(k))) hit = 1'b0;
               end
               if (hit) begin
                  offset     = seen_q - eff;
                  reported_q = 1'b1;
                  got        = 1'b1;
                  r.found    = 1'b1;
                  r.start    = (offset > StartMax) ? StartMax : offset[StartW-1:0];
               end
            end
         end
      end
   endtask

   task automatic send_word(input char_type b, input logic eot, input bit typed,
                            input bit want_result, input match_type want);
      bit        got;
      match_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      search_step(b, eot, got, r);
      if (typed) begin
         got = want_result;
         r   = want;
      end
      if (got) expected_matches.push_back(r);
      words_sent++;
      if (eot) texts_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results(input int settle);
      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrW-1:0] a, input logic [CsrDataW-1:0] d);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      case (a)
         RegPatLow:  pat_lo  = d;
         RegPatHigh: pat_hi  = d;
         RegPatLen:  pat_len = d[LenW-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_text;
      int n, k, pick, spoil;
      logic [LenW-1:0] eff;
      eff = used_len();
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6);
      repeat (n) send_word(noise_byte(), 1'b0, 1'b0, 1'b0, NotFound);
      pick = $urandom_range(9);
      if (pick <= 7 && eff != 0) begin
         // a spoiled copy has one byte replaced
         spoil = (pick == 7) ? $urandom_range(eff - 1) : -1;
         for (k = 0; k < eff; k++) begin
            send_word((k == spoil) ? noise_byte() : flip_case(raw_pattern_byte(k)),
                      1'b0, 1'b0, 1'b0, NotFound);
         end
      end
      repeat ($urandom_range(4)) send_word(noise_byte(), 1'b0, 1'b0, 1'b0, NotFound);
      if ($urandom_range(9) != 0) begin
         send_word(char_type'($urandom), 1'b1, 1'b0, 1'b0, NotFound);
      end
   endtask

   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HoldOffCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      match_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matches.size() == 0) begin
            $error("unexpected result word: match_found %0b match_start %0d",
                   rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("match_found: expected %0b, got %0b", want.found, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== want.start) begin
               $error("match_start: expected %0d, got %0d", want.start, rsp_tdata);
               errors++;
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int r, s, start_sent;
      foreach (window_q[r]) window_q[r] = '0;
      seen_q     = '0;
      reported_q = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (r = 0; r < $size(plan); r++) begin
         if (plan[r].kind == ROW_WRITE) begin
            drain_results(SettleCycles);
            write_reg(plan[r].addr, plan[r].wdata);
         end else begin
            send_word(plan[r].text, plan[r].eot, plan[r].typed, plan[r].produced,
                      plan[r].want);
         end
      end

      for (s = 0; s < $size(SettingLens); s++) begin
         drain_results(SettleCycles);
         case (s / 3)
            0: begin send_idle_pct = 29; recv_idle_pct = 84; end
            1: begin send_idle_pct = 84; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_reg(RegPatLow,  (s == 2) ? '1 : random_pattern_word());
         write_reg(RegPatHigh, (s == 2) ? '1 : random_pattern_word());
         write_reg(RegPatLen,  CsrDataW'(SettingLens[s]));
         settings_used++;
         if (s == 6) hold_toggle <= ~hold_toggle;
         start_sent = words_sent;
         while (words_sent - start_sent < WordsPerSetting) send_random_text();
      end

      drain_results(20);
      $display("sent %0d words in %0d texts, checked %0d results over %0d pattern settings",
               words_sent, texts_sent, results_checked, settings_used);
      $display("stalls on both sides, a long receiver hold-off, empty and clamped lengths");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
